// ----- hw/rtl/tpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared widths, types and helpers for the tube point query pipeline.
// ----------------------------------------------------------------------------
package tpq_pkg;

  // Coordinate format
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = COORD_W - 1;
  localparam int NORM_W     = FRAC_W + 2;
  localparam int MAG_W      = NORM_W - 1;
  localparam int REG_IDX_W  = 3;

  // Internal widths
  localparam int D_W        = COORD_W + 1;      // point minus offset
  localparam int SUM_W      = COORD_W + 2;      // near point before saturation
  localparam int DIST_W     = COORD_W + 2;      // surface distances
  localparam int R2_W       = 2 * D_W;          // squared radial distance
  localparam int ROOT_W     = D_W;              // integer square root
  localparam int NUM_W      = 2 * COORD_W;      // divider numerator
  localparam int QUO_W      = COORD_W;          // divider quotient
  localparam int SQ_STAGES  = ROOT_W;
  localparam int DIV_STAGES = QUO_W;
  localparam int DIV_LANES  = 4;

  // Divider lanes
  localparam int LANE_NEAR_X = 0;
  localparam int LANE_NEAR_Y = 1;
  localparam int LANE_NORM_X = 2;
  localparam int LANE_NORM_Y = 3;

  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [RAD_W-1:0]   rad_t;
  typedef logic signed [D_W-1:0]     diff_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
  typedef logic        [R2_W-1:0]    r2_t;
  typedef logic        [ROOT_W-1:0]  root_t;
  typedef logic        [NUM_W-1:0]   num_t;
  typedef logic        [QUO_W-1:0]   quo_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic        [MAG_W-1:0]   mag_t;

  typedef enum logic [1:0] {
    SURF_BOTTOM = 2'd0,
    SURF_TOP    = 2'd1,
    SURF_INNER  = 2'd2,
    SURF_OUTER  = 2'd3
  } surf_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INNER_RADIUS = 3'd0,
    REG_OUTER_RADIUS = 3'd1,
    REG_BOTTOM_Z     = 3'd2,
    REG_TOP_Z        = 3'd3,
    REG_OFFSET_X     = 3'd4,
    REG_OFFSET_Y     = 3'd5,
    REG_OFFSET_Z     = 3'd6
  } cfg_reg_t;

  // Sideband carried through the square root
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    logic  below;
    logic  above;
  } sq_ctx_t;

  // Sideband carried through the divider
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
    logic  below;
    logic  above;
    logic  r_zero;
    dist_t d0;
    dist_t d1;
    dist_t d2;
    dist_t d3;
  } dv_ctx_t;

  // Magnitude of a difference
  function automatic logic [D_W-1:0] mag_of(input diff_t v);
    return v[D_W-1] ? D_W'(-v) : D_W'(v);
  endfunction

  // Saturate to the coordinate range
  function automatic coord_t sat_coord(input sum_t v);
    sum_t hi;
    sum_t lo;
    hi = sum_t'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    lo = sum_t'($signed({1'b1, {(COORD_W-1){1'b0}}}));
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/tpq_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tpq_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             vld_in,
  input  tpq_pkg::r2_t     rad_in,
  input  tpq_pkg::sq_ctx_t ctx_in,
  output logic             vld_out,
  output tpq_pkg::root_t   root_out,
  output tpq_pkg::sq_ctx_t ctx_out
);

  tpq_pkg::r2_t     rem_q  [tpq_pkg::SQ_STAGES];
  tpq_pkg::root_t   root_q [tpq_pkg::SQ_STAGES];
  tpq_pkg::r2_t     rem_n  [tpq_pkg::SQ_STAGES];
  tpq_pkg::root_t   root_n [tpq_pkg::SQ_STAGES];
  tpq_pkg::sq_ctx_t ctx_q  [tpq_pkg::SQ_STAGES];
  logic             vld_q  [tpq_pkg::SQ_STAGES];

  // Try one root bit: keep it when the remainder covers (2*root + 2^b) * 2^b
  function automatic logic [tpq_pkg::R2_W+tpq_pkg::ROOT_W-1:0] sq_step(
    input tpq_pkg::r2_t rem, input tpq_pkg::root_t root, input int b);
    tpq_pkg::r2_t t;
    t = (tpq_pkg::r2_t'(root) << (b + 1)) | (tpq_pkg::r2_t'(1) << (2 * b));
    if (rem >= t) return {rem - t, root | (tpq_pkg::root_t'(1) << b)};
    return {rem, root};
  endfunction

  // Next remainder and partial root of every stage
  always_comb begin
    {rem_n[0], root_n[0]} = sq_step(rad_in, '0, tpq_pkg::SQ_STAGES - 1);
    for (int i = 1; i < tpq_pkg::SQ_STAGES; i++) begin
      {rem_n[i], root_n[i]} = sq_step(rem_q[i-1], root_q[i-1], tpq_pkg::SQ_STAGES - 1 - i);
    end
  end

  // Advance payload and sideband
  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_q[0] <= ctx_in;
      for (int i = 0; i < tpq_pkg::SQ_STAGES; i++) begin
        rem_q[i]  <= rem_n[i];
        root_q[i] <= root_n[i];
      end
      for (int i = 1; i < tpq_pkg::SQ_STAGES; i++) begin
        ctx_q[i] <= ctx_q[i-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tpq_pkg::SQ_STAGES; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= vld_in;
      for (int i = 1; i < tpq_pkg::SQ_STAGES; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  assign vld_out  = vld_q[tpq_pkg::SQ_STAGES-1];
  assign root_out = root_q[tpq_pkg::SQ_STAGES-1];
  assign ctx_out  = ctx_q[tpq_pkg::SQ_STAGES-1];

endmodule

// ----- hw/rtl/tpq_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_div
// Pipelined restoring divider, several lanes over one shared divisor,
// one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tpq_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             vld_in,
  input  tpq_pkg::num_t    num_in [tpq_pkg::DIV_LANES],
  input  tpq_pkg::root_t   den_in,
  input  tpq_pkg::dv_ctx_t ctx_in,
  output logic             vld_out,
  output tpq_pkg::quo_t    quo_out [tpq_pkg::DIV_LANES],
  output tpq_pkg::dv_ctx_t ctx_out
);

  tpq_pkg::num_t    rem_q [tpq_pkg::DIV_STAGES][tpq_pkg::DIV_LANES];
  tpq_pkg::quo_t    quo_q [tpq_pkg::DIV_STAGES][tpq_pkg::DIV_LANES];
  tpq_pkg::num_t    rem_n [tpq_pkg::DIV_STAGES][tpq_pkg::DIV_LANES];
  tpq_pkg::quo_t    quo_n [tpq_pkg::DIV_STAGES][tpq_pkg::DIV_LANES];
  tpq_pkg::root_t   den_q [tpq_pkg::DIV_STAGES];
  tpq_pkg::dv_ctx_t ctx_q [tpq_pkg::DIV_STAGES];
  logic             vld_q [tpq_pkg::DIV_STAGES];

  // Subtract the shifted divisor where it fits and set the quotient bit
  function automatic logic [tpq_pkg::NUM_W+tpq_pkg::QUO_W-1:0] div_step(
    input tpq_pkg::num_t rem, input tpq_pkg::quo_t quo, input tpq_pkg::root_t den,
    input int b);
    logic [tpq_pkg::NUM_W:0] shd;
    shd = {{(tpq_pkg::NUM_W + 1 - tpq_pkg::ROOT_W){1'b0}}, den} << b;
    if ({1'b0, rem} >= shd) begin
      return {rem - shd[tpq_pkg::NUM_W-1:0], quo | (tpq_pkg::quo_t'(1) << b)};
    end
    return {rem, quo};
  endfunction

  // Next remainder and partial quotient of every stage and lane
  always_comb begin
    for (int l = 0; l < tpq_pkg::DIV_LANES; l++) begin
      {rem_n[0][l], quo_n[0][l]} = div_step(num_in[l], '0, den_in,
                                            tpq_pkg::DIV_STAGES - 1);
    end
    for (int i = 1; i < tpq_pkg::DIV_STAGES; i++) begin
      for (int l = 0; l < tpq_pkg::DIV_LANES; l++) begin
        {rem_n[i][l], quo_n[i][l]} = div_step(rem_q[i-1][l], quo_q[i-1][l], den_q[i-1],
                                              tpq_pkg::DIV_STAGES - 1 - i);
      end
    end
  end

  // Advance payload and sideband
  always_ff @(posedge clk) begin
    if (adv) begin
      den_q[0] <= den_in;
      ctx_q[0] <= ctx_in;
      for (int i = 0; i < tpq_pkg::DIV_STAGES; i++) begin
        rem_q[i] <= rem_n[i];
        quo_q[i] <= quo_n[i];
      end
      for (int i = 1; i < tpq_pkg::DIV_STAGES; i++) begin
        den_q[i] <= den_q[i-1];
        ctx_q[i] <= ctx_q[i-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tpq_pkg::DIV_STAGES; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= vld_in;
      for (int i = 1; i < tpq_pkg::DIV_STAGES; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  assign vld_out = vld_q[tpq_pkg::DIV_STAGES-1];
  assign quo_out = quo_q[tpq_pkg::DIV_STAGES-1];
  assign ctx_out = ctx_q[tpq_pkg::DIV_STAGES-1];

endmodule

// ----- hw/rtl/tube_point_query.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tube_point_query
// Point query against a hollow cylinder: containment, nearest point of the
// solid, closest surface and its unit normal.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//   request  | in        | in_valid/in_stall   | point_x, point_y, point_z
//   result   | out       | out_valid/out_stall | is_inside .. normal_z
//
// One request enters per cycle while in_stall is low; its result passes
// through stages 0 to 2, the square root, stage 3, the divider, stage F and
// the output register. The square root resolves one bit per stage, and so
// does the four-lane divider.
// Reset is synchronous; it clears all valid bits and loads the register
// defaults. cfg_ready is always high.
// While a result waits under out_stall the whole pipeline holds and
// in_stall is raised; otherwise every stage advances each cycle.
// ----------------------------------------------------------------------------
module tube_point_query (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpq_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [tpq_pkg::COORD_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tpq_pkg::coord_t                    point_x,
  input  tpq_pkg::coord_t                    point_y,
  input  tpq_pkg::coord_t                    point_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               is_inside,
  output logic [1:0]                         surface_id,
  output tpq_pkg::coord_t                    near_x,
  output tpq_pkg::coord_t                    near_y,
  output tpq_pkg::coord_t                    near_z,
  output tpq_pkg::norm_t                     normal_x,
  output tpq_pkg::norm_t                     normal_y,
  output tpq_pkg::norm_t                     normal_z
);

  // Configuration registers
  tpq_pkg::rad_t   inner_radius;
  tpq_pkg::rad_t   outer_radius;
  tpq_pkg::coord_t bottom_z;
  tpq_pkg::coord_t top_z;
  tpq_pkg::coord_t offset_x;
  tpq_pkg::coord_t offset_y;
  tpq_pkg::coord_t offset_z;
  logic [2*tpq_pkg::RAD_W-1:0] sq_in;
  logic [2*tpq_pkg::RAD_W-1:0] sq_out;
  logic [2*tpq_pkg::RAD_W-1:0] sq_in_next;
  logic [2*tpq_pkg::RAD_W-1:0] sq_out_next;

  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= '0;
      outer_radius <= tpq_pkg::rad_t'(tpq_pkg::ONE_MAG);
      bottom_z     <= '0;
      top_z        <= tpq_pkg::coord_t'(tpq_pkg::ONE_MAG);
      offset_x     <= '0;
      offset_y     <= '0;
      offset_z     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpq_pkg::REG_INNER_RADIUS: inner_radius <= cfg_data[tpq_pkg::RAD_W-1:0];
        tpq_pkg::REG_OUTER_RADIUS: outer_radius <= cfg_data[tpq_pkg::RAD_W-1:0];
        tpq_pkg::REG_BOTTOM_Z:     bottom_z     <= cfg_data;
        tpq_pkg::REG_TOP_Z:        top_z        <= cfg_data;
        tpq_pkg::REG_OFFSET_X:     offset_x     <= cfg_data;
        tpq_pkg::REG_OFFSET_Y:     offset_y     <= cfg_data;
        tpq_pkg::REG_OFFSET_Z:     offset_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Squared radii, refreshed every cycle from the registers
  assign sq_in_next  = inner_radius * inner_radius;
  assign sq_out_next = outer_radius * outer_radius;

  always_ff @(posedge clk) begin
    sq_in  <= sq_in_next;
    sq_out <= sq_out_next;
  end

  // --------------------------------------------------------------------------
  // Stage 0: subtract the offset
  // --------------------------------------------------------------------------
  logic           s0_valid;
  tpq_pkg::diff_t s0_dx, s0_dy, s0_dz;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (adv) s0_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dx <= tpq_pkg::diff_t'(point_x) - tpq_pkg::diff_t'(offset_x);
      s0_dy <= tpq_pkg::diff_t'(point_y) - tpq_pkg::diff_t'(offset_y);
      s0_dz <= tpq_pkg::diff_t'(point_z) - tpq_pkg::diff_t'(offset_z);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: square the radial components
  // --------------------------------------------------------------------------
  logic                  s1_valid;
  tpq_pkg::diff_t        s1_dx, s1_dy, s1_dz;
  tpq_pkg::r2_t          s1_sqx, s1_sqy;
  logic [tpq_pkg::D_W-1:0] s0_ax, s0_ay;
  tpq_pkg::r2_t          s0_sqx, s0_sqy;

  assign s0_ax  = tpq_pkg::mag_of(s0_dx);
  assign s0_ay  = tpq_pkg::mag_of(s0_dy);
  assign s0_sqx = s0_ax * s0_ax;
  assign s0_sqy = s0_ay * s0_ay;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= s0_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx  <= s0_dx;
      s1_dy  <= s0_dy;
      s1_dz  <= s0_dz;
      s1_sqx <= s0_sqx;
      s1_sqy <= s0_sqy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sum of squares and radius band tests
  // --------------------------------------------------------------------------
  logic             s2_valid;
  tpq_pkg::r2_t     s2_r2;
  tpq_pkg::sq_ctx_t s2_ctx;
  tpq_pkg::r2_t     s1_r2;

  assign s1_r2 = s1_sqx + s1_sqy;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r2        <= s1_r2;
      s2_ctx.dx    <= s1_dx;
      s2_ctx.dy    <= s1_dy;
      s2_ctx.dz    <= s1_dz;
      s2_ctx.below <= s1_r2 < tpq_pkg::r2_t'(sq_in);
      s2_ctx.above <= s1_r2 > tpq_pkg::r2_t'(sq_out);
    end
  end

  // --------------------------------------------------------------------------
  // Radial distance
  // --------------------------------------------------------------------------
  logic             sq_vld;
  tpq_pkg::root_t   sq_root;
  tpq_pkg::sq_ctx_t sq_ctx;

  tpq_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .vld_in   (s2_valid),
    .rad_in   (s2_r2),
    .ctx_in   (s2_ctx),
    .vld_out  (sq_vld),
    .root_out (sq_root),
    .ctx_out  (sq_ctx)
  );

  // --------------------------------------------------------------------------
  // Stage 3: divider numerators and surface distances
  // --------------------------------------------------------------------------
  logic                    p_valid;
  tpq_pkg::num_t           p_num [tpq_pkg::DIV_LANES];
  tpq_pkg::root_t          p_den;
  tpq_pkg::dv_ctx_t        p_ctx;
  tpq_pkg::num_t           p_num_next [tpq_pkg::DIV_LANES];
  tpq_pkg::dv_ctx_t        p_ctx_next;
  logic [tpq_pkg::D_W-1:0] p_ax, p_ay;
  tpq_pkg::rad_t           p_k;
  tpq_pkg::num_t           p_half;
  tpq_pkg::dist_t          p_rr, p_t2, p_t3;

  always_comb begin
    p_ax   = tpq_pkg::mag_of(sq_ctx.dx);
    p_ay   = tpq_pkg::mag_of(sq_ctx.dy);
    p_k    = sq_ctx.below ? inner_radius : outer_radius;
    p_half = tpq_pkg::num_t'(sq_root >> 1);

    p_num_next[tpq_pkg::LANE_NEAR_X] = p_ax * p_k + p_half;
    p_num_next[tpq_pkg::LANE_NEAR_Y] = p_ay * p_k + p_half;
    p_num_next[tpq_pkg::LANE_NORM_X] = (tpq_pkg::num_t'(p_ax) << tpq_pkg::FRAC_W) + p_half;
    p_num_next[tpq_pkg::LANE_NORM_Y] = (tpq_pkg::num_t'(p_ay) << tpq_pkg::FRAC_W) + p_half;

    p_rr = tpq_pkg::dist_t'(sq_root);
    p_t2 = p_rr - tpq_pkg::dist_t'(inner_radius);
    p_t3 = p_rr - tpq_pkg::dist_t'(outer_radius);

    p_ctx_next.dx     = sq_ctx.dx;
    p_ctx_next.dy     = sq_ctx.dy;
    p_ctx_next.dz     = sq_ctx.dz;
    p_ctx_next.below  = sq_ctx.below;
    p_ctx_next.above  = sq_ctx.above;
    p_ctx_next.r_zero = (sq_root == '0);
    p_ctx_next.d0     = tpq_pkg::dist_t'(sq_ctx.dz) - tpq_pkg::dist_t'(bottom_z);
    p_ctx_next.d1     = tpq_pkg::dist_t'(top_z) - tpq_pkg::dist_t'(sq_ctx.dz);
    p_ctx_next.d2     = (p_t2 < 0) ? -p_t2 : p_t2;
    p_ctx_next.d3     = (p_t3 < 0) ? -p_t3 : p_t3;
  end

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (adv) p_valid <= sq_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_num <= p_num_next;
      p_den <= sq_root;
      p_ctx <= p_ctx_next;
    end
  end

  // --------------------------------------------------------------------------
  // Radial scaling and normals
  // --------------------------------------------------------------------------
  logic             dv_vld;
  tpq_pkg::quo_t    dv_quo [tpq_pkg::DIV_LANES];
  tpq_pkg::dv_ctx_t dv_ctx;

  tpq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .vld_in  (p_valid),
    .num_in  (p_num),
    .den_in  (p_den),
    .ctx_in  (p_ctx),
    .vld_out (dv_vld),
    .quo_out (dv_quo),
    .ctx_out (dv_ctx)
  );

  // --------------------------------------------------------------------------
  // Stage F: surface choice, nearest point, normal magnitudes
  // --------------------------------------------------------------------------
  logic            f_valid;
  logic            f_inside;
  tpq_pkg::surf_t  f_surf;
  tpq_pkg::coord_t f_near_x, f_near_y, f_near_z;
  tpq_pkg::mag_t   f_mag_x, f_mag_y;
  logic            f_neg_x, f_neg_y;
  logic            f_r_zero;

  tpq_pkg::surf_t  c_surf;
  tpq_pkg::dist_t  c_best;
  tpq_pkg::sum_t   c_nx, c_ny, c_qx, c_qy;
  tpq_pkg::diff_t  c_cz;
  logic            c_lo;
  tpq_pkg::mag_t   c_mag_x, c_mag_y;

  always_comb begin
    // Closest of bottom, top, inner, outer, first on ties; cap if z not inside
    c_best = dv_ctx.d0;
    c_surf = tpq_pkg::SURF_BOTTOM;
    if (dv_ctx.d1 < c_best) begin
      c_best = dv_ctx.d1;
      c_surf = tpq_pkg::SURF_TOP;
    end
    if (dv_ctx.d2 < c_best) begin
      c_best = dv_ctx.d2;
      c_surf = tpq_pkg::SURF_INNER;
    end
    if (dv_ctx.d3 < c_best) begin
      c_surf = tpq_pkg::SURF_OUTER;
    end
    if (dv_ctx.d0 <= 0) c_surf = tpq_pkg::SURF_BOTTOM;
    else if (dv_ctx.d1 <= 0) c_surf = tpq_pkg::SURF_TOP;

    // Radial part of the nearest point
    c_qx = tpq_pkg::sum_t'(dv_quo[tpq_pkg::LANE_NEAR_X]);
    c_qy = tpq_pkg::sum_t'(dv_quo[tpq_pkg::LANE_NEAR_Y]);
    if (dv_ctx.r_zero) begin
      c_nx = tpq_pkg::sum_t'(inner_radius);
      c_ny = '0;
    end else if (dv_ctx.below || dv_ctx.above) begin
      c_nx = dv_ctx.dx[tpq_pkg::D_W-1] ? -c_qx : c_qx;
      c_ny = dv_ctx.dy[tpq_pkg::D_W-1] ? -c_qy : c_qy;
    end else begin
      c_nx = tpq_pkg::sum_t'(dv_ctx.dx);
      c_ny = tpq_pkg::sum_t'(dv_ctx.dy);
    end

    // Clamp z: first to top, then to bottom
    c_lo = (dv_ctx.d1 < 0) ? (top_z < bottom_z) : (dv_ctx.d0 < 0);
    if (c_lo) c_cz = tpq_pkg::diff_t'(bottom_z);
    else if (dv_ctx.d1 < 0) c_cz = tpq_pkg::diff_t'(top_z);
    else c_cz = dv_ctx.dz;

    // Normal magnitudes, held to one
    c_mag_x = (dv_quo[tpq_pkg::LANE_NORM_X] > tpq_pkg::quo_t'(tpq_pkg::ONE_MAG)) ?
              tpq_pkg::ONE_MAG : dv_quo[tpq_pkg::LANE_NORM_X][tpq_pkg::MAG_W-1:0];
    c_mag_y = (dv_quo[tpq_pkg::LANE_NORM_Y] > tpq_pkg::quo_t'(tpq_pkg::ONE_MAG)) ?
              tpq_pkg::ONE_MAG : dv_quo[tpq_pkg::LANE_NORM_Y][tpq_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (adv) f_valid <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_inside <= !dv_ctx.below && !dv_ctx.above && (dv_ctx.d0 >= 0) && (dv_ctx.d1 >= 0);
      f_surf   <= c_surf;
      f_near_x <= tpq_pkg::sat_coord(c_nx + tpq_pkg::sum_t'(offset_x));
      f_near_y <= tpq_pkg::sat_coord(c_ny + tpq_pkg::sum_t'(offset_y));
      f_near_z <= tpq_pkg::sat_coord(tpq_pkg::sum_t'(c_cz) + tpq_pkg::sum_t'(offset_z));
      f_mag_x  <= c_mag_x;
      f_mag_y  <= c_mag_y;
      f_neg_x  <= dv_ctx.dx[tpq_pkg::D_W-1];
      f_neg_y  <= dv_ctx.dy[tpq_pkg::D_W-1];
      f_r_zero <= dv_ctx.r_zero;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: normal of the chosen surface
  // --------------------------------------------------------------------------
  tpq_pkg::norm_t o_nx, o_ny, o_nz, o_one, o_mx, o_my;
  logic           o_inner;

  always_comb begin
    o_one   = tpq_pkg::norm_t'(tpq_pkg::ONE_MAG);
    o_mx    = tpq_pkg::norm_t'(f_mag_x);
    o_my    = tpq_pkg::norm_t'(f_mag_y);
    o_inner = (f_surf == tpq_pkg::SURF_INNER);
    o_nx    = '0;
    o_ny    = '0;
    o_nz    = '0;
    unique case (f_surf)
      tpq_pkg::SURF_BOTTOM: o_nz = -o_one;
      tpq_pkg::SURF_TOP:    o_nz = o_one;
      tpq_pkg::SURF_INNER,
      tpq_pkg::SURF_OUTER: begin
        if (f_r_zero) begin
          o_nx = o_inner ? -o_one : o_one;
        end else begin
          o_nx = (f_neg_x ^ o_inner) ? -o_mx : o_mx;
          o_ny = (f_neg_y ^ o_inner) ? -o_my : o_my;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= f_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_inside  <= f_inside;
      surface_id <= f_surf;
      near_x     <= f_near_x;
      near_y     <= f_near_y;
      near_z     <= f_near_z;
      normal_x   <= o_nx;
      normal_y   <= o_ny;
      normal_z   <= o_nz;
    end
  end

`ifndef SYNTHESIS
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken while result is held");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> ($stable(out_valid) && $stable(near_x) && $stable(normal_x)))
    else $error("pipeline moved while stalled");

  a_cap_normal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (surface_id == tpq_pkg::SURF_BOTTOM || surface_id == tpq_pkg::SURF_TOP))
    |-> (normal_x == '0 && normal_y == '0 && normal_z != '0))
    else $error("cap normal not along z");

  a_side_normal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (surface_id == tpq_pkg::SURF_INNER || surface_id == tpq_pkg::SURF_OUTER))
    |-> (normal_z == '0))
    else $error("side normal has z part");
`endif

endmodule
